// File: design/stoi_pkg.sv
// Shared types, constants and digit decoding for the string-to-integer parser.
`default_nettype none

package stoi_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int RADIX_WIDTH = 6;
    localparam int CHAR_WIDTH  = 8;
    localparam int OUT_VALUE_WIDTH = 64;
    localparam int OUT_COUNT_WIDTH = 16;
    localparam int DIGIT_WIDTH = 7;

    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET  = RADIX_WIDTH'(10);
    localparam logic [RADIX_WIDTH-1:0] RADIX_DETECT = RADIX_WIDTH'(0);
    localparam logic [RADIX_WIDTH-1:0] RADIX_DEC    = RADIX_WIDTH'(10);
    localparam logic [RADIX_WIDTH-1:0] RADIX_OCT    = RADIX_WIDTH'(8);
    localparam logic [RADIX_WIDTH-1:0] RADIX_HEX    = RADIX_WIDTH'(16);

    localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7A;

    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = DIGIT_WIDTH'(64);
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN  = DIGIT_WIDTH'(10);

    typedef enum logic [2:0] {
        PH_WS,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic                              valid;
        logic signed [OUT_VALUE_WIDTH-1:0] value;
        logic [OUT_COUNT_WIDTH-1:0]        consumed;
    } stoi_res_t;

    function automatic logic [DIGIT_WIDTH-1:0] digit_val(input logic [CHAR_WIDTH-1:0] c);
        logic [DIGIT_WIDTH-1:0] d;
        begin
            if (c >= CH_0 && c <= CH_9)
                d = DIGIT_WIDTH'(c - CH_0);
            else if (c >= CH_LA && c <= CH_LZ)
                d = DIGIT_WIDTH'(c - CH_LA) + DIGIT_TEN;
            else if (c >= CH_UA && c <= CH_UZ)
                d = DIGIT_WIDTH'(c - CH_UA) + DIGIT_TEN;
            else
                d = DIGIT_NONE;
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/string_to_integer_parser.sv
// Top level of the streaming strtol-style string-to-integer parser.
//
//   channel   direction  handshake               word
//   cfg       in         radix_we                radix[5:0]
//   input     in         in_valid / in_ready     ch[7:0]
//   output    out        out_valid / out_ready   value[63:0], consumed[15:0]
//
// One character per cycle while the parse stage is not stalled; a character waits in the input
// register, and its result word is then held in the result register around the parse stage.
// The parse stage stalls only while a result word waits and out_ready is low.
// Reset gives radix 10 and an empty string state; no clearing pass.
`default_nettype none

module string_to_integer_parser
    import stoi_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         radix_we,
    input  wire logic [RADIX_WIDTH-1:0]       radix,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [CHAR_WIDTH-1:0]        ch,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [OUT_VALUE_WIDTH-1:0] value,
    output logic [OUT_COUNT_WIDTH-1:0]        consumed
);

    logic                  held_valid;
    logic [CHAR_WIDTH-1:0] held_ch;
    logic                  can_load;
    logic                  step;
    stoi_res_t             res;

    assign step = held_valid && can_load;

    stoi_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .take       (step),
        .held_valid (held_valid),
        .held_ch    (held_ch)
    );

    stoi_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix),
        .step        (step),
        .c           (held_ch),
        .res         (res)
    );

    stoi_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .consumed  (consumed)
    );

endmodule

`default_nettype wire

// File: design/stoi_in_reg.sv
// Input word register: holds one character until the parse stage takes it.
`default_nettype none

module stoi_in_reg
    import stoi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CHAR_WIDTH-1:0] ch,
    input  wire logic                  take,
    output logic                       held_valid,
    output logic [CHAR_WIDTH-1:0]      held_ch
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [CHAR_WIDTH-1:0] ch_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_ch    = ch_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ch_reg <= ch;
    end

endmodule

`default_nettype wire

// File: design/stoi_core.sv
// Parse stage: per-string state, radix register, digit accumulate and result build.
`default_nettype none

module stoi_core
    import stoi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   radix_we,
    input  wire logic [RADIX_WIDTH-1:0] radix_wdata,
    input  wire logic                   step,
    input  wire logic [CHAR_WIDTH-1:0]  c,
    output stoi_res_t                   res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [RADIX_WIDTH-1:0] radix_reg;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [VALUE_WIDTH-1:0] accum_reg;
    logic [VALUE_WIDTH-1:0] accum_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [RADIX_WIDTH-1:0] ar_reg;
    logic [RADIX_WIDTH-1:0] ar_next;

    logic [RADIX_WIDTH-1:0]             ar_sel;
    logic                               go_prefix;
    logic                               go_digit;
    logic                               bump;
    logic                               clear;
    logic                               emit;
    logic [DIGIT_WIDTH-1:0]             dval;
    logic [VALUE_WIDTH+RADIX_WIDTH-1:0] prod;
    logic [VALUE_WIDTH-1:0]             mag;

    assign dval = digit_val(c);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        ar_next    = ar_reg;
        ar_sel     = ar_reg;
        prod       = '0;
        go_prefix  = 1'b0;
        go_digit   = 1'b0;
        bump       = 1'b0;
        clear      = 1'b0;
        emit       = 1'b0;

        unique case (phase_reg)
            PH_WS:
            begin
                ar_sel = radix_reg;
                if (c == CH_SPACE || c == CH_TAB)
                    bump = 1'b1;
                else if (c == CH_MINUS || c == CH_PLUS)
                begin
                    neg_next   = (c == CH_MINUS);
                    bump       = 1'b1;
                    phase_next = PH_PREFIX;
                    ar_next    = radix_reg;
                end
                else
                    go_prefix = 1'b1;
            end
            PH_PREFIX:
                go_prefix = 1'b1;
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                begin
                    ar_next    = RADIX_HEX;
                    bump       = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    if (ar_reg == RADIX_DETECT)
                        ar_sel = RADIX_OCT;
                    go_digit = 1'b1;
                end
            end
            PH_DIGITS:
                go_digit = 1'b1;
            PH_DONE:
                clear = (c == CH_NUL);
            default:
                clear = 1'b1;
        endcase

        if (go_prefix)
        begin
            if (ar_sel == RADIX_DETECT && c != CH_0)
            begin
                ar_sel   = RADIX_DEC;
                go_digit = 1'b1;
            end
            else if ((ar_sel == RADIX_DETECT || ar_sel == RADIX_HEX) && c == CH_0)
            begin
                bump       = 1'b1;
                phase_next = PH_ZERO;
                ar_next    = ar_sel;
            end
            else
                go_digit = 1'b1;
        end

        if (go_digit)
        begin
            if (c == CH_NUL)
            begin
                emit  = 1'b1;
                clear = 1'b1;
            end
            else if (dval >= DIGIT_WIDTH'(ar_sel))
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
                ar_next    = ar_sel;
            end
            else
            begin
                prod       = accum_reg * ar_sel;
                accum_next = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dval);
                bump       = 1'b1;
                phase_next = PH_DIGITS;
                ar_next    = ar_sel;
            end
        end

        if (bump && count_reg != CNT_MAX)
            count_next = count_reg + COUNT_WIDTH'(1);

        if (clear)
        begin
            phase_next = PH_WS;
            neg_next   = 1'b0;
            accum_next = '0;
            count_next = '0;
            ar_next    = '0;
        end
    end

    // result word, built from state before this character
    always_comb
    begin
        mag          = neg_reg ? (~accum_reg + VALUE_WIDTH'(1)) : accum_reg;
        res.valid    = step && emit;
        res.value    = OUT_VALUE_WIDTH'($signed(mag));
        res.consumed = OUT_COUNT_WIDTH'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            phase_reg <= PH_WS;
            neg_reg   <= 1'b0;
            accum_reg <= '0;
            count_reg <= '0;
            ar_reg    <= '0;
        end
        else
        begin
            if (radix_we)
                radix_reg <= radix_wdata;
            if (step)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                accum_reg <= accum_next;
                count_reg <= count_next;
                ar_reg    <= ar_next;
            end
        end
    end

    a_res_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> step)
        else $error("result without a step");

    a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && c == CH_NUL) |=> (phase_reg == PH_WS && count_reg == '0 && accum_reg == '0))
        else $error("NUL did not restart the string");

    a_digits_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGITS) |-> (ar_reg != RADIX_DETECT))
        else $error("digit phase with no base");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && c == CH_NUL) |=> (count_reg >= $past(count_reg)))
        else $error("count went backward");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(accum_reg) && $stable(phase_reg)))
        else $error("state moved without a step");

endmodule

`default_nettype wire

// File: design/stoi_out_reg.sv
// Output word register: holds one result until the consumer takes it.
`default_nettype none

module stoi_out_reg
    import stoi_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  stoi_res_t                         res,
    output logic                              can_load,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [OUT_VALUE_WIDTH-1:0] value,
    output logic [OUT_COUNT_WIDTH-1:0]        consumed
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [OUT_VALUE_WIDTH-1:0] value_reg;
    logic [OUT_COUNT_WIDTH-1:0]        consumed_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign value     = value_reg;
    assign consumed  = consumed_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            value_reg    <= res.value;
            consumed_reg <= res.consumed;
        end
    end

endmodule

`default_nettype wire
